### rtl/crcsc_pkg.sv
// shared constants and types of the crc-32 memory self-check block
package crcsc_pkg;

	localparam int unsigned DATA_W = 8;
	localparam int unsigned CRC_W  = 32;
	localparam int unsigned OUT_W  = 40;

	localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

	typedef logic [CRC_W-1:0]  crc_t;
	typedef logic [DATA_W-1:0] byte_t;

endpackage

### rtl/crcsc_fold.sv
// one-byte reflected crc-32 update, eight unrolled shift steps
module crcsc_fold
	import crcsc_pkg::*;
(
	input  crc_t  crc_in,
	input  byte_t data,
	output crc_t  crc_out
);

	always_comb begin
		crc_t c;
		c = crc_in ^ {{(CRC_W-DATA_W){1'b0}}, data};
		for (int k = 0; k < DATA_W; k++) begin
			c = (c >> 1) ^ (CRC_POLY & {CRC_W{c[0]}});
		end
		crc_out = c;
	end

endmodule

### rtl/crc32_self_check.sv
// top level of the crc-32 memory self-check block
//
//   channel  dir  payload                                       handshake
//   s_       in   tdata[7:0] data_byte, tlast last_byte         tvalid/tready
//   m_       out  tdata crc_value, captured, mismatch, fault    tvalid/tready
//
// one byte per cycle unless a held result stalls a last byte; the crc fold and
// the pass check sit between the input register and the result register
// a pass result is loaded into the result register from its last byte in the input register
// arst_n clears running crc to all ones, reference and fault flag to zero
// a held result stalls only a last byte in the input register; other bytes flow
module crc32_self_check
	import crcsc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // data_byte
	input  logic             s_tlast,   // last_byte
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // crc_value, captured, mismatch, fault, zero fill
);

	logic  valid_s1;
	byte_t data_s1;
	logic  last_s1;
	crc_t  running_q;
	crc_t  ref_q;
	logic  ref_valid_q;
	logic  fault_q;
	crc_t  crc_next;
	crc_t  final_crc;
	logic  advance;
	logic  done;
	logic  mismatch;
	logic  out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	crcsc_fold u_fold (
		.crc_in  (running_q),
		.data    (data_s1),
		.crc_out (crc_next)
	);

	assign final_crc = ~crc_next;
	assign advance   = !(valid_s1 && last_s1) || !out_valid_q || m_tready;
	assign done      = valid_s1 && last_s1 && advance;
	assign mismatch  = ref_valid_q && (final_crc != ref_q);
	assign s_tready  = !valid_s1 || advance;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// running crc and pass state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q   <= CRC_INIT;
			ref_q       <= '0;
			ref_valid_q <= 1'b0;
			fault_q     <= 1'b0;
		end else if (valid_s1 && advance) begin
			if (last_s1) begin
				running_q <= CRC_INIT;
				if (!ref_valid_q) begin
					ref_q       <= final_crc;
					ref_valid_q <= 1'b1;
				end
				if (mismatch) begin
					fault_q <= 1'b1;
				end
			end else begin
				running_q <= crc_next;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_data_q <= {{(OUT_W-CRC_W-3){1'b0}}, fault_q | mismatch, mismatch,
				!ref_valid_q, final_crc};
		end
	end

	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(fault_q))
		else $error("fault flag cleared after being set");

	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> running_q == CRC_INIT)
		else $error("running crc not re-armed after pass end");

	a_capture_once: assert property (@(posedge clk) disable iff (!arst_n)
		done && !ref_valid_q |=> ref_valid_q && ref_q == out_data_q[CRC_W-1:0])
		else $error("reference not captured from first pass");

	a_result_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_data_q[CRC_W] && out_data_q[CRC_W+1])
			&& (!out_data_q[CRC_W+1] || out_data_q[CRC_W+2]))
		else $error("inconsistent result flags");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// self-checking testbench of the crc-32 memory self-check block
module tb;
	import crcsc_pkg::*;

	localparam int N_ITEMS     = 950;
	localparam int IMAGE_LEN   = 6;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		byte_t data;
		logic  last;
		logic  drain;
	} mem_beat_t;

	typedef struct {
		crc_t crc;
		logic captured;
		logic mismatch;
		logic fault;
	} pass_result_t;

	logic             clk      = 1'b0;
	logic             arst_n   = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [7:0]       s_tdata  = '0;
	logic             s_tlast  = 1'b0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	mem_beat_t    beat_q[$];
	pass_result_t pass_q[$];

	crc_t  run_crc    = CRC_INIT;
	crc_t  golden_crc = '0;
	logic  golden_ok  = 1'b0;
	logic  fault_seen = 1'b0;
	byte_t golden_image [IMAGE_LEN] = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h01, 8'h80};

	int   errors    = 0;
	int   cycles    = 0;
	int   n_items   = 0;
	int   send_wait = 0;
	int   recv_wait = 0;
	logic send_calm = 1'b0;
	logic recv_calm = 1'b0;

	crc32_self_check u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic crc_t fold_byte(crc_t c, byte_t b);
		crc_t r;
		r = c ^ crc_t'(b);
		for (int k = 0; k < 8; k++)
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		return r;
	endfunction

	function void predict_beat(mem_beat_t b);
		crc_t         c;
		pass_result_t r;
		c = fold_byte(run_crc, b.data);
		if (!b.last) begin
			run_crc = c;
			return;
		end
		run_crc    = CRC_INIT;
		r.crc      = ~c;
		r.captured = 1'b0;
		r.mismatch = 1'b0;
		if (!golden_ok) begin
			golden_crc = r.crc;
			golden_ok  = 1'b1;
			r.captured = 1'b1;
		end else if (r.crc != golden_crc) begin
			r.mismatch = 1'b1;
			fault_seen = 1'b1;
		end
		r.fault = fault_seen;
		pass_q.push_back(r);
	endfunction

	task automatic push_beat(input byte_t d, input logic l, input logic dr);
		beat_q.push_back('{data: d, last: l, drain: dr});
		n_items++;
	endtask

	// the golden image, optionally with one damaged byte or a missing tail
	task automatic push_image(input logic corrupt, input logic dr);
		byte_t img [IMAGE_LEN];
		int    len;
		int    pos;
		img = golden_image;
		len = IMAGE_LEN;
		if (corrupt) begin
			pos = $urandom_range(0, IMAGE_LEN - 1);
			case ($urandom_range(0, 2))
				0: img[pos][$urandom_range(0, 7)] ^= 1'b1;
				1: img[pos] = byte_t'($urandom);
				default: len = $urandom_range(1, IMAGE_LEN - 1);
			endcase
		end
		for (int i = 0; i < len; i++)
			push_beat(img[i], i == len - 1, dr && i == 0);
	endtask

	always @(posedge clk or negedge arst_n) begin : drive
		logic      vld;
		mem_beat_t b;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tlast  <= 1'b0;
		end else begin
			vld = s_tvalid;
			if (s_tvalid && s_tready) begin
				predict_beat(beat_q.pop_front());
				vld = 1'b0;
				if ($urandom_range(0, 63) == 0)
					send_calm = !send_calm;
				send_wait = send_calm ? 0 : $urandom_range(0, 8);
			end
			if (!vld) begin
				if (send_wait > 0)
					send_wait--;
				else if (beat_q.size() > 0 && !(beat_q[0].drain && pass_q.size() > 0)) begin
					b = beat_q[0];
					vld = 1'b1;
					s_tdata <= b.data;
					s_tlast <= b.last;
				end
			end
			s_tvalid <= vld;
		end
	end

	always @(posedge clk or negedge arst_n) begin : watch
		pass_result_t want;
		crc_t         got_crc;
		logic         got_cap;
		logic         got_mis;
		logic         got_flt;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_crc = m_tdata[CRC_W-1:0];
				got_cap = m_tdata[CRC_W];
				got_mis = m_tdata[CRC_W+1];
				got_flt = m_tdata[CRC_W+2];
				if (pass_q.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("unexpected result: crc %h captured %b mismatch %b fault %b",
							got_crc, got_cap, got_mis, got_flt);
				end else begin
					want = pass_q.pop_front();
					if (got_crc !== want.crc || got_cap !== want.captured ||
						got_mis !== want.mismatch || got_flt !== want.fault) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("result mismatch: exp crc %h cap %b mis %b flt %b, got crc %h cap %b mis %b flt %b",
								want.crc, want.captured, want.mismatch, want.fault,
								got_crc, got_cap, got_mis, got_flt);
					end
				end
				if ($urandom_range(0, 15) == 0)
					recv_calm = !recv_calm;
				recv_wait = recv_calm ? 0 : $urandom_range(0, 8);
			end
			if (recv_wait > 0) begin
				recv_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		logic drain;
		logic first;
		int   len;

		// capture pass, clean compare, single-byte mismatches, compare after fault, a two-byte pass
		push_image(1'b0, 1'b0);
		push_image(1'b0, 1'b0);
		push_beat(8'hFF, 1'b1, 1'b0);
		push_beat(8'h00, 1'b1, 1'b0);
		push_image(1'b0, 1'b0);
		push_beat(8'h00, 1'b0, 1'b0);
		push_beat(8'hFF, 1'b1, 1'b0);

		first = 1'b1;
		while (n_items < N_ITEMS) begin
			drain = first || ($urandom_range(0, 11) == 0);
			first = 1'b0;
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: push_image(1'b0, drain);
				6, 7: push_image(1'b1, drain);
				default: begin
					len = $urandom_range(1, 12);
					for (int i = 0; i < len; i++)
						push_beat(byte_t'($urandom), i == len - 1, drain && i == 0);
				end
			endcase
		end

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (beat_q.size() != 0 || s_tvalid || pass_q.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
